// ===== hdl/deq_pkg.sv =====
// Package for the double-ended queue: capacity, derived widths and codes.
// No dependencies; used by double_ended_queue and its testbench.
package deq_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  function automatic idx_t idx_inc(idx_t i);
    idx_inc = (i == idx_t'(CAPACITY - 1)) ? '0 : i + idx_t'(1);
  endfunction

  function automatic idx_t idx_dec(idx_t i);
    idx_dec = (i == '0) ? idx_t'(CAPACITY - 1) : i - idx_t'(1);
  endfunction

endpackage

// ===== hdl/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit words over a circular buffer in RAM.
// Depends on deq_pkg and deq_ram.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o   | operation_i, push_value_i
//  out     | output    | out_valid_o / out_ready_i | popped_value_o, status_o
//
// One beat in per cycle while in_ready_o is high; its result is registered at acceptance,
// the popped word in the registered read port of the entry RAM. Pointers and count update at acceptance,
// so a pop right after a push of the same entry sees the written word.
// in_ready_o falls only while a result waits and out_ready_i is low.
// Reset clears pointers, count and the output valid; the RAM needs no clearing.
module double_ended_queue
  import deq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] push_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] popped_value_o,
  output logic [1:0]         status_o
);

  idx_t    head_q, head_d;
  idx_t    tail_q, tail_d;
  cnt_t    count_q, count_d;
  logic    out_valid_q;
  logic    pop_ok_q;
  status_e status_q, status_d;

  logic    accept;
  logic    is_push, is_full, is_empty;
  logic    ram_we, ram_re;
  idx_t    ram_addr;
  op_e     op;
  logic [DATA_W-1:0] ram_rdata;

  assign op         = op_e'(operation_i);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_push    = (op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK);
  assign is_full    = (count_q == cnt_t'(CAPACITY));
  assign is_empty   = (count_q == '0);

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    status_d = ST_OK;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = head_q;
    unique case (op)
      OP_PUSH_FRONT: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          head_d   = idx_dec(head_q);
          ram_addr = idx_dec(head_q);
          ram_we   = accept;
          count_d  = count_q + cnt_t'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          ram_addr = tail_q;
          tail_d   = idx_inc(tail_q);
          ram_we   = accept;
          count_d  = count_q + cnt_t'(1);
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          ram_addr = head_q;
          head_d   = idx_inc(head_q);
          ram_re   = accept;
          count_d  = count_q - cnt_t'(1);
        end
      end
      OP_POP_BACK: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          tail_d   = idx_dec(tail_q);
          ram_addr = idx_dec(tail_q);
          ram_re   = accept;
          count_d  = count_q - cnt_t'(1);
        end
      end
      default: ;
    endcase
  end

  deq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .rd_en_i (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (push_value_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pop_ok_q    <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      if (accept) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
        pop_ok_q    <= !is_push && (status_d == ST_OK);
        status_q    <= status_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = pop_ok_q ? $signed(ram_rdata) : 32'sd0;

  // tail must sit count entries past head, modulo the capacity
  logic [CNT_W:0] span;
  idx_t           tail_expect;
  assign span        = {1'b0, count_q} + {{(CNT_W + 1 - IDX_W){1'b0}}, head_q};
  assign tail_expect = (span >= (CNT_W + 1)'(CAPACITY)) ?
                       IDX_W'(span - (CNT_W + 1)'(CAPACITY)) : IDX_W'(span);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(CAPACITY))
    else $error("entry count above capacity");

  a_ptr_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q == tail_expect)
    else $error("head, tail and count disagree");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> popped_value_o == 32'sd0)
    else $error("rejected beat carries a value");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_empty && !is_push |=> out_valid_o && status_o == ST_EMPTY)
    else $error("pop on empty queue not flagged");

endmodule

// ===== hdl/deq_ram.sv =====
// Single-port synchronous RAM, one write, one read or both per cycle at the one address.
// Read data is registered and holds while rd_en_i is low. No dependencies.
module deq_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
